// ===== sv/c2p_pkg.sv =====
package c2p_pkg;

  // Build constants
  localparam int ITERATIONS  = 16;
  localparam int COORD_WIDTH = 16;
  localparam int TABLE_LEN   = 24;
  localparam int FIELD_W     = 16;

  // Derived widths
  localparam int CW    = COORD_WIDTH;
  localparam int XW    = COORD_WIDTH + 11;   // guard bits, CORDIC gain, sign
  localparam int ZW    = 32;                 // angle accumulator, 22 fractional bits
  localparam int SQW   = 2 * COORD_WIDTH;    // x*x + y*y
  localparam int RW    = COORD_WIDTH;        // integer square root
  localparam int NSTEP = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;
  localparam int NST   = (RW > NSTEP) ? RW : NSTEP;
  localparam int GUARD = 8;
  localparam int ANG_FRAC  = 22;
  localparam int ANG_SHIFT = ANG_FRAC - 7;

  localparam logic signed [ZW-1:0] HALF_TURN = ZW'(180) <<< ANG_FRAC;
  localparam logic signed [ZW-1:0] FULL_TURN = ZW'(360) <<< ANG_FRAC;
  localparam logic [ZW-1:0]        ANG_HALF  = ZW'(1) << (ANG_SHIFT - 1);
  localparam int ANG_OUT_FULL = 46080;
  localparam int RAD_MAX      = 65535;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // atan(2^-i) in degrees, 22 fractional bits
  localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
    32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
    32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
    32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
    32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
    32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
    32'sd229,       32'sd115,       32'sd57,       32'sd29
  };

  // One point in flight: square-root remainder and root, CORDIC vector and angle
  typedef struct packed {
    logic [SQW-1:0]        rem;
    logic [RW-1:0]         root;
    logic signed [XW-1:0]  cx;
    logic signed [XW-1:0]  cy;
    logic signed [ZW-1:0]  z;
    logic                  origin;
  } c2p_work_t;

endpackage

// ===== sv/c2p_front.sv =====
module c2p_front
  import c2p_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FIELD_W-1:0] x_coord,
  input  logic [FIELD_W-1:0] y_coord,
  output logic               push,
  input  logic               full,
  output c2p_work_t          push_data
);

  logic                  v1, v2, adv1, adv2;
  logic signed [CW-1:0]  x1, y1, xs, ys;
  logic signed [CW:0]    xe, ye, nx, ny;
  logic signed [SQW-1:0] xw, yw;
  logic [SQW-1:0]        xx, yy;
  logic signed [XW-1:0]  cx2, cy2;
  logic                  neg2, org2;

  assign xs = signed'(CW'(x_coord));
  assign ys = signed'(CW'(y_coord));

  assign adv2     = !v2 || !full;
  assign adv1     = !v1 || adv2;
  assign in_stall = !adv1;

  // stage 1: capture
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      x1 <= xs;
      y1 <= ys;
    end
  end

  // stage 2: squares and half-plane fold
  assign xe = {x1[CW-1], x1};
  assign ye = {y1[CW-1], y1};
  assign nx = x1[CW-1] ? -xe : xe;
  assign ny = x1[CW-1] ? -ye : ye;
  assign xw = SQW'(x1);
  assign yw = SQW'(y1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      xx   <= unsigned'(xw * xw);
      yy   <= unsigned'(yw * yw);
      cx2  <= XW'(nx) <<< GUARD;
      cy2  <= XW'(ny) <<< GUARD;
      neg2 <= x1[CW-1];
      org2 <= (x1 == '0) && (y1 == '0);
    end
  end

  assign push = v2 && !full;

  always_comb begin
    push_data.rem    = xx + yy;
    push_data.root   = '0;
    push_data.cx     = cx2;
    push_data.cy     = cy2;
    push_data.z      = neg2 ? HALF_TURN : '0;
    push_data.origin = org2;
  end

endmodule

// ===== sv/c2p_queue.sv =====
module c2p_queue
  import c2p_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  c2p_work_t push_data,
  output logic      full,
  input  logic      pop,
  output c2p_work_t head,
  output logic      empty
);

  c2p_work_t      mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;

  assign full  = (count == (QAW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("queue occupancy above depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

endmodule

// ===== sv/c2p_back.sv =====
module c2p_back
  import c2p_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  c2p_work_t          head,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] radius,
  output logic [FIELD_W-1:0] angle_deg
);

  localparam int RCW = (RW + 1 > FIELD_W + 1) ? RW + 1 : FIELD_W + 1;

  c2p_work_t      work [NST];
  logic [NST-1:0] vld;
  logic           en;

  // whole pipe moves unless the output register holds a stalled transaction
  assign en  = !(out_valid && out_stall);
  assign pop = en && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], pop};
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_stage
    localparam int B  = (k < RW) ? RW - 1 - k : 0;
    localparam int SH = (k < NSTEP) ? k : 0;
    c2p_work_t src, nxt;

    if (k == 0) begin : g_first
      assign src = head;
    end else begin : g_next
      assign src = work[k-1];
    end

    always_comb begin
      logic [SQW-1:0] trial;
      nxt   = src;
      trial = (SQW'(src.root) << (B + 1)) | (SQW'(1) << (2 * B));
      // one root bit per stage, restoring
      if (k < RW) begin
        if (src.rem >= trial) begin
          nxt.rem  = src.rem - trial;
          nxt.root = src.root | (RW'(1) << B);
        end
      end
      // one vectoring micro-rotation per stage
      if (k < NSTEP) begin
        if (src.cy >= 0) begin
          nxt.cx = src.cx + (src.cy >>> SH);
          nxt.cy = src.cy - (src.cx >>> SH);
          nxt.z  = src.z + ATAN_TAB[SH];
        end else begin
          nxt.cx = src.cx - (src.cy >>> SH);
          nxt.cy = src.cy + (src.cx >>> SH);
          nxt.z  = src.z - ATAN_TAB[SH];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        work[k] <= nxt;
      end
    end
  end

  // final rounding
  c2p_work_t              last;
  logic [RCW-1:0]         rnd;
  logic signed [ZW-1:0]   zw;
  logic [ZW-1:0]          zr;
  logic [ZW-ANG_SHIFT-1:0] ang_w;
  logic [FIELD_W-1:0]     rad_next, ang_next;

  assign last = work[NST-1];

  always_comb begin
    rnd      = RCW'(last.root) + RCW'(last.rem > SQW'(last.root));
    rad_next = (rnd > RCW'(RAD_MAX)) ? FIELD_W'(RAD_MAX) : FIELD_W'(rnd);
    zw       = (last.z < 0) ? last.z + FULL_TURN : last.z;
    zr       = unsigned'(zw) + ANG_HALF;
    ang_w    = zr[ZW-1:ANG_SHIFT];
    if (last.origin || ang_w >= (ZW-ANG_SHIFT)'(ANG_OUT_FULL)) begin
      ang_next = '0;
    end else begin
      ang_next = FIELD_W'(ang_w);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[NST-1]) begin
      radius    <= rad_next;
      angle_deg <= ang_next;
    end
  end

  a_origin_angle: assert property (@(posedge clk) disable iff (rst)
    en && vld[NST-1] && last.origin |=> angle_deg == '0)
    else $error("origin gave nonzero angle");

endmodule

// ===== sv/cartesian_to_polar_unit.sv =====
// Cartesian to polar conversion, one point per transaction.
// Input channel: in_valid / in_stall with x_coord, y_coord (signed Q8.8).
// Output channel: out_valid / out_stall with radius (Q8.8, exact rounded
//   square root of x*x + y*y) and angle_deg (1/128 degree, 0 to under 360).
// Structure: a two-stage front registers the point, forms both squares and
//   folds the left half-plane onto the right; a four-entry queue decouples it
//   from the back, a pipeline of max(COORD_WIDTH, min(ITERATIONS, TABLE_LEN))
//   stages, each doing one root bit and one CORDIC micro-rotation, then an
//   output register that rounds and wraps.
// Throughput: one transaction per cycle when out_stall stays low.
// Path from input acceptance to out_valid through an empty block: the two
//   front stages, the queue, the back stages and the output register; the
//   back stage count sets its length.
// Reset (rst, synchronous) empties every stage and the queue; no results
//   are pending afterwards and nothing needs clearing.
// When the receiver stalls, the output register and the whole back pipeline
//   hold; the front keeps accepting until the queue and both front stages
//   are full, and then in_stall rises. Results come out in acceptance order.
module cartesian_to_polar_unit
  import c2p_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FIELD_W-1:0] x_coord,
  input  logic [FIELD_W-1:0] y_coord,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] radius,
  output logic [FIELD_W-1:0] angle_deg
);

  // front to queue
  logic      push, full;
  c2p_work_t push_data;

  // queue to back
  logic      pop, empty;
  c2p_work_t head;

  c2p_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .push      (push),
    .full      (full),
    .push_data (push_data)
  );

  c2p_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  c2p_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .radius    (radius),
    .angle_deg (angle_deg)
  );

endmodule

// ===== dv/tb_cartesian_to_polar_unit.sv =====
module tb_cartesian_to_polar_unit
  import c2p_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Angle arithmetic of the predictor: degrees with 22 fraction bits,
  // output in 1/128 degree.
  localparam int     ANGLE_FRAC  = 22;
  localparam int     OUT_SHIFT   = ANGLE_FRAC - 7;
  localparam longint FULL_CIRCLE = longint'(360) << ANGLE_FRAC;
  localparam longint HALF_CIRCLE = longint'(180) << ANGLE_FRAC;
  localparam int     TURN_UNITS  = 46080;
  localparam int     ATAN_STEPS  = 24;
  localparam int     RADIUS_SAT  = 65535;

  localparam int RANDOM_POINTS = 1150;
  localparam int HOLD_AFTER    = 400;    // points accepted before the long hold-off
  localparam int HOLD_CYCLES   = 150;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 300000;

  typedef struct packed {
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
  } point_t;

  typedef struct packed {
    point_t             pt;
    logic [FIELD_W-1:0] rad;
    logic [FIELD_W-1:0] ang;
  } polar_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [FIELD_W-1:0] x_coord   = '0;
  logic [FIELD_W-1:0] y_coord   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [FIELD_W-1:0] radius;
  logic [FIELD_W-1:0] angle_deg;

  point_t points_to_send [$];
  polar_t polar_expected [$];

  logic in_fire = 1'b0;          // input transaction taken at the last rising edge
  int   points_accepted = 0;
  int   results_checked = 0;
  int   mismatches      = 0;
  int   cycle_count     = 0;
  int   quad_hits [4]   = '{0, 0, 0, 0};
  bit   hold_done       = 1'b0;

  cartesian_to_polar_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .radius    (radius),
    .angle_deg (angle_deg)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // atan(2^-i) in degrees, 22 fraction bits
  function automatic longint atan_step_deg(input int i);
    case (i)
      0:  return 188743680;
      1:  return 111421900;
      2:  return 58872272;
      3:  return 29884485;
      4:  return 15000234;
      5:  return 7507429;
      6:  return 3754631;
      7:  return 1877430;
      8:  return 938729;
      9:  return 469366;
      10: return 234683;
      11: return 117342;
      12: return 58671;
      13: return 29335;
      14: return 14668;
      15: return 7334;
      16: return 3667;
      17: return 1833;
      18: return 917;
      19: return 458;
      20: return 229;
      21: return 115;
      22: return 57;
      default: return 29;
    endcase
  endfunction

  // Low COORD_WIDTH bits as two's complement
  function automatic longint coord_value(input logic [FIELD_W-1:0] raw);
    logic [63:0] u;
    u = 64'(raw) & ((64'd1 << COORD_WIDTH) - 64'd1);
    if (u[COORD_WIDTH-1])
      return longint'(u) - (longint'(1) << COORD_WIDTH);
    return longint'(u);
  endfunction

  function automatic polar_t predict_polar(input point_t pt);
    polar_t      res;
    longint      px, py, cx, cy, nx, ny, z;
    logic [63:0] sq, root, trial, ang;
    int          i;
    res.pt = pt;
    px = coord_value(pt.x);
    py = coord_value(pt.y);

    // Exact root, built bit by bit, then rounded to nearest
    sq   = 64'(px * px) + 64'(py * py);
    root = '0;
    for (i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= sq)
        root = trial;
    end
    if (sq - root * root > root)
      root = root + 64'd1;
    if (root > 64'(RADIUS_SAT))
      root = 64'(RADIUS_SAT);
    res.rad = root[FIELD_W-1:0];

    if (px == 0 && py == 0) begin
      res.ang = '0;
      return res;
    end

    // Left half-plane folded over, then CORDIC vectoring with 8 guard bits
    z  = 0;
    cx = px;
    cy = py;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      z  = HALF_CIRCLE;
    end
    cx = cx * 256;
    cy = cy * 256;
    for (i = 0; i < ITERATIONS && i < ATAN_STEPS; i++) begin
      if (cy >= 0) begin
        nx = cx + (cy >>> i);
        ny = cy - (cx >>> i);
        z  = z + atan_step_deg(i);
      end else begin
        nx = cx - (cy >>> i);
        ny = cy + (cx >>> i);
        z  = z - atan_step_deg(i);
      end
      cx = nx;
      cy = ny;
    end

    while (z < 0)
      z = z + FULL_CIRCLE;
    while (z >= FULL_CIRCLE)
      z = z - FULL_CIRCLE;
    ang = (64'(z) + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    if (ang >= 64'(TURN_UNITS))
      ang = ang - 64'(TURN_UNITS);
    res.ang = ang[FIELD_W-1:0];
    return res;
  endfunction

  task automatic queue_point(input int xv, input int yv);
    point_t pt;
    pt.x = FIELD_W'(xv);
    pt.y = FIELD_W'(yv);
    points_to_send.push_back(pt);
  endtask

  // Sender: bursts of random length, random gaps between them.
  // The payload is held while in_stall keeps the transaction pending.
  int     burst_left = 0;
  int     gap_left   = 0;
  point_t next_pt;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_fire)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (points_to_send.size() > 0) begin
        next_pt = points_to_send.pop_front();
        x_coord  <= next_pt.x;
        y_coord  <= next_pt.y;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 7))
            0, 1, 2: gap_left = 0;
            3:       gap_left = $urandom_range(10, 25);
            default: gap_left = $urandom_range(1, 5);
          endcase
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern of its own, with its mode picked anew at random,
  // plus one long hold-off so the queue and pipeline fill and in_stall rises.
  stall_mode_e stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          hold_left  = 0;
  int          period     = 2;
  int          phase      = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && points_accepted >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 120);
        period     = $urandom_range(2, 5);
      end
      mode_left = mode_left - 1;
      phase     = phase + 1;
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: out_stall <= (phase % period == 0);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // Sampling at the rising edge: result check first, then the prediction
  // for any input transaction taken at this edge.
  polar_t oldest;

  always @(posedge clk) begin
    in_fire <= !rst && in_valid && !in_stall;
    if (!rst && out_valid && !out_stall) begin
      if (polar_expected.size() == 0) begin
        $display("%0t: result with none expected: radius %0d angle %0d",
                 $time, radius, angle_deg);
        mismatches = mismatches + 1;
      end else begin
        oldest = polar_expected.pop_front();
        results_checked = results_checked + 1;
        if (radius !== oldest.rad) begin
          $display("%0t: radius for (%0d,%0d): expected %0d, actual %0d", $time,
                   $signed(oldest.pt.x), $signed(oldest.pt.y), oldest.rad, radius);
          mismatches = mismatches + 1;
        end
        if (angle_deg !== oldest.ang) begin
          $display("%0t: angle_deg for (%0d,%0d): expected %0d, actual %0d", $time,
                   $signed(oldest.pt.x), $signed(oldest.pt.y), oldest.ang, angle_deg);
          mismatches = mismatches + 1;
        end
      end
    end
    if (!rst && in_valid && !in_stall) begin
      oldest = predict_polar(point_t'{x: x_coord, y: y_coord});
      polar_expected.push_back(oldest);
      points_accepted = points_accepted + 1;
      quad_hits[oldest.ang / 11520] = quad_hits[oldest.ang / 11520] + 1;
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, polar_expected.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int xv, yv, pick, n;
    int extremes [6];
    extremes = '{-32768, -32767, -1, 0, 1, 32767};

    // Directed: origin, axes both ways, corners, unit steps, diagonals,
    // and a point just below the positive x axis whose angle wraps to 0.
    queue_point(0, 0);
    queue_point(32767, 0);
    queue_point(-32768, 0);
    queue_point(0, 32767);
    queue_point(0, -32768);
    queue_point(32767, 32767);
    queue_point(-32768, -32768);
    queue_point(-32768, 32767);
    queue_point(32767, -32768);
    queue_point(1, 0);
    queue_point(-1, 0);
    queue_point(0, 1);
    queue_point(0, -1);
    queue_point(1, 1);
    queue_point(-1, 1);
    queue_point(-1, -1);
    queue_point(1, -1);
    queue_point(32767, -1);
    queue_point(32767, 1);
    queue_point(-32768, -1);
    queue_point(-32768, 1);
    queue_point(256, 256);
    queue_point(-256, 443);
    queue_point(12345, -23456);

    for (n = 0; n < RANDOM_POINTS; n++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3: begin                     // full range
          xv = $urandom_range(0, 65535);
          yv = $urandom_range(0, 65535);
        end
        4, 5: begin                           // near the origin
          xv = $urandom_range(0, 512) - 256;
          yv = $urandom_range(0, 512) - 256;
        end
        6: begin                              // on an axis
          xv = $urandom_range(0, 65535);
          yv = 0;
          if ($urandom_range(0, 1)) begin
            yv = xv;
            xv = 0;
          end
        end
        7: begin                              // on a diagonal
          xv = $urandom_range(0, 65535) - 32768;
          yv = $urandom_range(0, 1) ? xv : -xv;
        end
        8: begin                              // extreme values
          xv = extremes[$urandom_range(0, 5)];
          yv = extremes[$urandom_range(0, 5)];
        end
        default: begin                        // just off an axis
          xv = $urandom_range(0, 65535) - 32768;
          yv = $urandom_range(0, 6) - 3;
          if ($urandom_range(0, 1)) begin
            pick = xv;
            xv = yv;
            yv = pick;
          end
        end
      endcase
      queue_point(xv, yv);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(posedge clk); while (points_to_send.size() != 0 || in_valid);
    while (polar_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d points sent, %0d results checked, long output hold-off %s",
             points_accepted, results_checked, hold_done ? "done" : "not reached");
    $display("results per quadrant: %0d %0d %0d %0d",
             quad_hits[0], quad_hits[1], quad_hits[2], quad_hits[3]);
    if (mismatches == 0 && polar_expected.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
